FILE: rtl/core/bpm_pkg.sv
// Shared constants, register codes and interface types of the byte pattern matcher.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bpm_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;

    localparam int PATTERN_BYTES = 16;
    localparam int LEN_BITS      = 5;
    localparam int LEN_IDX_BITS  = 4;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int OFFSET_BITS   = 32;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [LEN_IDX_BITS-1:0]       len_m1;
    } cfg_t;

    typedef struct packed {
        logic shift_en;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/bpm_cfg.sv
// Configuration registers of the byte pattern matcher and the clamped pattern length.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [bpm_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    output bpm_pkg::cfg_t                      cfg
);

    logic [63:0]                    pattern_low_reg;
    logic [63:0]                    pattern_high_reg;
    logic [bpm_pkg::LEN_BITS-1:0]   pattern_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= bpm_pkg::LEN_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bpm_pkg::CFG_PATTERN_LOW: begin
                    pattern_low_reg <= cfg_wr_data[63:0];
                end
                bpm_pkg::CFG_PATTERN_HIGH: begin
                    pattern_high_reg <= cfg_wr_data[63:0];
                end
                bpm_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wr_data[bpm_pkg::LEN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.pattern = {pattern_high_reg, pattern_low_reg};
        if (pattern_length_reg == '0) begin
            cfg.len_m1 = '0;
        end else if (pattern_length_reg > bpm_pkg::LEN_BITS'(bpm_pkg::MAX_PATTERN)) begin
            cfg.len_m1 = bpm_pkg::LEN_IDX_BITS'(bpm_pkg::MAX_PATTERN - 1);
        end else begin
            cfg.len_m1 = bpm_pkg::LEN_IDX_BITS'(pattern_length_reg - bpm_pkg::LEN_BITS'(1));
        end
    end

endmodule

FILE: rtl/core/bpm_cell.sv
// One window cell: holds one stream byte and its valid bit, compares the byte it takes in
// against its pattern byte and extends the match chain. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          byte_in,
    input  logic                valid_in,
    input  logic                match_in,
    input  logic [7:0]          pattern_byte,
    input  logic                in_use,
    output logic [7:0]          byte_out,
    output logic                valid_out,
    output logic                match_out
);

    logic [7:0] byte_reg;
    logic       valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift_en) begin
            valid_reg <= valid_in && !ctrl.clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;
    assign match_out = match_in && (!in_use || (valid_in && (byte_in == pattern_byte)));

endmodule

FILE: rtl/core/byte_pattern_matcher_top.sv
// Top level of the byte pattern matcher: chain of window cells, stream position and
// result register. Depends on bpm_pkg, bpm_cfg and bpm_cell.
`timescale 1ns / 1ps

// Scans a byte stream at one byte per clock, unless a held result stalls it, and reports
// the start offset of every occurrence of the configured 1 to 16 byte pattern, overlapping
// ones included. A hit appears on the result port on the cycle after its request is taken,
// and a new request is taken in that cycle as long as the result register is empty or
// being drained. The window is a row of 16 byte cells that shift by one per request and
// compare in parallel, so throughput is one byte per clock while s_ready is high. After a
// request with s_last_byte set, the window and the position clear and the next byte is
// offset zero. The position saturates at its maximum. Write configuration only while idle.

module byte_pattern_matcher_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [bpm_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bpm_pkg::OFFSET_BITS-1:0]    m_match_offset
);

    localparam int N = bpm_pkg::MAX_PATTERN;
    localparam int PB = bpm_pkg::POSITION_BITS;

    bpm_pkg::cfg_t       cfg;
    bpm_pkg::cell_ctrl_t ctrl;

    logic [N:0][7:0] chain_byte;
    logic [N:0]      chain_valid;
    logic [N:0]      chain_match;

    logic [PB-1:0] position_reg;
    logic [PB-1:0] position_next;
    logic [PB-1:0] offset_full;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [bpm_pkg::OFFSET_BITS-1:0] m_offset_reg;
    logic          accept;

    bpm_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    assign s_ready       = !m_valid_reg || m_ready;
    assign accept        = s_valid && s_ready;
    assign ctrl.shift_en = accept;
    assign ctrl.clear    = s_last_byte;

    assign chain_byte[0]  = s_data_byte;
    assign chain_valid[0] = 1'b1;
    assign chain_match[0] = 1'b1;

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [bpm_pkg::LEN_IDX_BITS-1:0] pidx;
        logic                             use_k;

        assign pidx  = cfg.len_m1 - bpm_pkg::LEN_IDX_BITS'(k);
        assign use_k = (bpm_pkg::LEN_BITS'(k) <= {1'b0, cfg.len_m1});

        bpm_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .byte_in      (chain_byte[k]),
            .valid_in     (chain_valid[k]),
            .match_in     (chain_match[k]),
            .pattern_byte (cfg.pattern[pidx]),
            .in_use       (use_k),
            .byte_out     (chain_byte[k+1]),
            .valid_out    (chain_valid[k+1]),
            .match_out    (chain_match[k+1])
        );
    end

    assign offset_full = position_reg - PB'(cfg.len_m1);

    always_comb begin
        position_next = position_reg;
        if (accept) begin
            if (s_last_byte) begin
                position_next = '0;
            end else if (position_reg != {PB{1'b1}}) begin
                position_next = position_reg + PB'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = chain_match[N];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            position_reg <= position_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && chain_match[N]) begin
            m_offset_reg <= bpm_pkg::OFFSET_BITS'(offset_full);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_offset = m_offset_reg;

endmodule

FILE: verif/tb_byte_pattern_matcher_top.sv
// Self-checking testbench of byte_pattern_matcher_top: directed and random byte streams,
// with a cycle-free predictor of the match offsets and random stalls on both channels.
// Depends on bpm_pkg and the RTL of the byte pattern matcher.
`timescale 1ns / 1ps

module tb_byte_pattern_matcher_top;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam logic [bpm_pkg::CFG_ADDR_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              cfg_wr_en      = 1'b0;
    logic [bpm_pkg::CFG_ADDR_BITS-1:0] cfg_addr       = '0;
    logic [bpm_pkg::CFG_DATA_BITS-1:0] cfg_wr_data    = '0;
    logic                              s_valid        = 1'b0;
    logic                              s_ready;
    logic [7:0]                        s_data_byte    = 8'h00;
    logic                              s_last_byte    = 1'b0;
    logic                              m_valid;
    logic                              m_ready        = 1'b0;
    logic [bpm_pkg::OFFSET_BITS-1:0]   m_match_offset;

    // predictor state and its copy of the registers
    logic [63:0]                       pat_low  = '0;
    logic [63:0]                       pat_high = '0;
    logic [bpm_pkg::LEN_BITS-1:0]      pat_len  = 5'd1;
    logic [7:0]                        window_bytes [bpm_pkg::MAX_PATTERN];
    int                                window_fill;
    logic [bpm_pkg::POSITION_BITS-1:0] stream_pos;

    byte_req_t                         byte_requests [$];
    logic [bpm_pkg::OFFSET_BITS-1:0]   expected_offsets [$];
    idle_mode_t                        idle_mode    = IDLE_NONE;
    int                                error_count  = 0;
    int                                items_queued = 0;
    logic                              req_taken    = 1'b0;

    byte_pattern_matcher_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_offset (m_match_offset)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pattern_span();
        int n;
        n = int'(pat_len);
        if (n == 0) n = 1;
        if (n > bpm_pkg::MAX_PATTERN) n = bpm_pkg::MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(int i);
        return (i < 8) ? pat_low[i*8 +: 8] : pat_high[(i-8)*8 +: 8];
    endfunction

    function void clear_stream();
        foreach (window_bytes[i]) window_bytes[i] = 8'h00;
        window_fill = 0;
        stream_pos  = '0;
    endfunction

    function void predict_match(logic [7:0] data, logic last);
        int                                span;
        logic                              hit;
        logic [bpm_pkg::POSITION_BITS-1:0] start_pos;
        span = pattern_span();
        start_pos = stream_pos - bpm_pkg::POSITION_BITS'(span - 1);
        for (int i = bpm_pkg::MAX_PATTERN - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
        window_bytes[0] = data;
        if (window_fill < bpm_pkg::MAX_PATTERN) window_fill++;
        if (window_fill >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
                if (pattern_at(i) != window_bytes[span-1-i]) hit = 1'b0;
            end
            if (hit) expected_offsets.push_back(start_pos[bpm_pkg::OFFSET_BITS-1:0]);
        end
        if (stream_pos != '1) stream_pos++;
        if (last) clear_stream();
    endfunction

    function automatic bit roll_idle(idle_mode_t side);
        if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 12;
        if (idle_mode == side) return $urandom_range(99) < 61;
        return 1'b0;
    endfunction

    // predictor update on each taken request, and request driver
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_match(s_data_byte, s_last_byte);
            req_taken <= 1'b1;
        end
    end

    always @(negedge aclk) begin : drive_req
        byte_req_t req;
        if (!s_valid || req_taken) begin
            req_taken <= 1'b0;
            if (byte_requests.size() > 0 && !roll_idle(IDLE_SENDER)) begin
                req = byte_requests.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= req.data;
                s_last_byte <= req.last;
            end else begin
                s_valid     <= 1'b0;
                s_data_byte <= 8'($urandom);
                s_last_byte <= 1'($urandom_range(1));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !roll_idle(IDLE_RECEIVER);
    end

    // result monitor
    always @(posedge aclk) begin : check_result
        logic [bpm_pkg::OFFSET_BITS-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_offsets.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual match_offset %0d",
                         $time, m_match_offset);
            end else begin
                want = expected_offsets.pop_front();
                if (want !== m_match_offset) begin
                    error_count++;
                    $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                             $time, want, m_match_offset);
                end
            end
        end
    end

    task automatic cfg_write(logic [bpm_pkg::CFG_ADDR_BITS-1:0] idx,
                             logic [bpm_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            bpm_pkg::CFG_PATTERN_LOW:    pat_low  = val;
            bpm_pkg::CFG_PATTERN_HIGH:   pat_high = val;
            bpm_pkg::CFG_PATTERN_LENGTH: pat_len  = val[bpm_pkg::LEN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every request is taken and every result has arrived
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_requests.size() != 0 || s_valid || expected_offsets.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic queue_byte(logic [7:0] data, int last_pct);
        byte_requests.push_back('{data, ($urandom_range(99) < last_pct)});
        items_queued++;
    endtask

    task automatic add_stream(int count, int last_pct);
        int span;
        int cut;
        int stop;
        span = pattern_span();
        stop = items_queued + count;
        while (items_queued < stop) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (int j = 0; j < span; j++) queue_byte(pattern_at(j), last_pct);
                end
                4, 5: begin
                    cut = $urandom_range(span - 1);
                    for (int j = 0; j < cut; j++) queue_byte(pattern_at(j), last_pct);
                    queue_byte(8'($urandom), last_pct);
                end
                6, 7: queue_byte(pattern_at($urandom_range(span - 1)), last_pct);
                default: queue_byte(8'($urandom), last_pct);
            endcase
        end
    endtask

    task automatic random_config(int phase);
        logic [7:0]                   pat [bpm_pkg::PATTERN_BYTES];
        logic [7:0]                   alpha [4];
        logic [63:0]                  lo;
        logic [63:0]                  hi;
        logic [63:0]                  len_word;
        logic [bpm_pkg::LEN_BITS-1:0] len_sel;
        int                           period;
        case (phase % 7)
            0: len_sel = 5'd1;
            1: len_sel = 5'd16;
            2: len_sel = 5'd0;
            3: len_sel = 5'd17;
            4: len_sel = 5'd31;
            5: len_sel = 5'($urandom_range(1, 16));
            default: len_sel = 5'($urandom_range(2, 6));
        endcase
        period = $urandom_range(1, 4);
        foreach (alpha[i]) alpha[i] = 8'($urandom);
        foreach (pat[i]) begin
            pat[i] = ($urandom_range(2) == 0) ? 8'($urandom) : alpha[i % period];
        end
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = pat[i];
            hi[i*8 +: 8] = pat[i+8];
        end
        len_word = {$urandom, $urandom};
        if ($urandom_range(1)) len_word[63:bpm_pkg::LEN_BITS] = '0;
        len_word[bpm_pkg::LEN_BITS-1:0] = len_sel;
        cfg_write(bpm_pkg::CFG_PATTERN_LOW, lo);
        cfg_write(bpm_pkg::CFG_PATTERN_HIGH, hi);
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, len_word);
        if ($urandom_range(3) == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});
        cfg_close();
    endtask

    initial begin
        clear_stream();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset pattern: one zero byte
        queue_byte(8'h00, 0);
        queue_byte(8'hFF, 0);
        queue_byte(8'h00, 100);
        wait_idle();

        // full sixteen byte pattern closing a stream
        cfg_write(bpm_pkg::CFG_PATTERN_LOW, 64'h807F_01FE_55AA_FF00);
        cfg_write(bpm_pkg::CFG_PATTERN_HIGH, 64'h0FF0_3CC3_9669_E718);
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, 64'd16);
        cfg_close();
        for (int i = 0; i < bpm_pkg::MAX_PATTERN; i++) begin
            queue_byte(pattern_at(i), (i == 15) ? 100 : 0);
        end
        wait_idle();

        // zero length acts as one; unused index ignored
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        cfg_write(CFG_UNUSED, '1);
        cfg_close();
        queue_byte(8'h00, 0);
        queue_byte(8'h00, 0);
        wait_idle();

        // oversize length clamps to sixteen, window kept across the write
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, 64'd31);
        cfg_close();
        for (int i = 0; i < 4; i++) queue_byte(pattern_at(i), (i == 3) ? 100 : 0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            random_config(ph);
            idle_mode = idle_mode_t'(ph % 4);
            add_stream(70, (ph % 3) * 2);
            wait_idle();
        end

        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: byte_pattern_matcher_top.f
rtl/core/bpm_pkg.sv
rtl/core/bpm_cfg.sv
rtl/core/bpm_cell.sv
rtl/core/byte_pattern_matcher_top.sv
verif/tb_byte_pattern_matcher_top.sv
